// File: src/ipts_pkg.sv
// Shared types and constants for the incremental PD throttle step core.
// Depends on nothing; used by ipts_datapath and the top level.
package ipts_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_KP_GAIN          = 3'd0,
		REG_KD_GAIN          = 3'd1,
		REG_THROTTLE_FLOOR   = 3'd2,
		REG_THROTTLE_CEILING = 3'd3,
		REG_BRAKE_ENGAGED    = 3'd4,
		REG_BRAKE_RELEASED   = 3'd5,
		REG_SPEED_LIMIT      = 3'd6
	} reg_index_t;

	// Clutch gear codes; the spare code behaves as neutral
	typedef enum logic [1:0] {
		GEAR_NEUTRAL = 2'd0,
		GEAR_FORWARD = 2'd1,
		GEAR_REVERSE = 2'd2
	} gear_t;

	// 18/pi in Q16 (mrad to centidegrees)
	localparam logic [18:0] STEER_FACTOR_Q16 = 19'd375494;
	localparam logic [31:0] STEER_ROUND      = 32'd32768;
	// Command magnitude in mm/s at or below which braking is requested
	localparam logic [15:0] CMD_DEADBAND     = 16'd1;

	localparam logic [15:0] KP_GAIN_RESET          = 16'd256;
	localparam logic [15:0] KD_GAIN_RESET          = 16'd0;
	localparam logic [15:0] THROTTLE_FLOOR_RESET   = 16'd0;
	localparam logic [15:0] THROTTLE_CEILING_RESET = 16'd65535;
	localparam logic [15:0] BRAKE_ENGAGED_RESET    = 16'd65535;
	localparam logic [15:0] BRAKE_RELEASED_RESET   = 16'd0;
	localparam logic [14:0] SPEED_LIMIT_RESET      = 15'd1500;

	typedef struct packed {
		logic [15:0] kp_gain;
		logic [15:0] kd_gain;
		logic [15:0] throttle_floor;
		logic [15:0] throttle_ceiling;
		logic [15:0] brake_engaged;
		logic [15:0] brake_released;
		logic [14:0] speed_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] error_now;
		logic signed [15:0] error_prev;
		logic signed [15:0] error_older;
		logic signed [15:0] velocity_command;
		logic signed [12:0] steer_angle_in;
		logic        [1:0]  clutch_direction;
		logic signed [15:0] wheel_speed;
	} item_t;

	typedef struct packed {
		logic        [15:0] throttle_position;
		logic signed [15:0] steer_degrees;
		logic        [15:0] rear_brake_position;
		logic               next_mode;
	} result_t;

endpackage

// File: src/incremental_pd_throttle_step_core.sv
// Top level of the incremental PD throttle step core: configuration
// registers, input stage, throttle accumulator and result register.
// Depends on ipts_pkg and ipts_datapath.
//
// Usage
//  - Input channel (in_valid/in_ready) carries one word per control tick:
//    three speed errors, velocity command, steering angle, clutch gear and
//    wheel speed. Output channel (out_valid/out_ready) returns one word per
//    input word: throttle position, steering in centidegrees, rear brake
//    drive and the braking request.
//  - A word passes from the input register to the result register, which
//    drives the output. Throughput is one word per cycle while out_ready
//    holds, set by the accumulate-and-clamp loop around the accumulator.
//  - The input register and the result register part the two channels, so
//    a new word is taken while a finished result still waits.
//  - If the receiver stalls, the result holds, the input stage fills, and
//    in_ready drops until out_ready returns; nothing is lost or repeated.
//  - Reset (arst_n low) empties both stages, clears the accumulator, loads the
//    register defaults. The user writes registers via the plain cfg_wr_en/
//    cfg_index/cfg_data port only while the core is idle; it is not enforced.
module incremental_pd_throttle_step_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] error_now,
	input  logic signed [15:0] error_prev,
	input  logic signed [15:0] error_older,
	input  logic signed [15:0] velocity_command,
	input  logic signed [12:0] steer_angle_in,
	input  logic        [1:0]  clutch_direction,
	input  logic signed [15:0] wheel_speed,

	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] throttle_position,
	output logic signed [15:0] steer_degrees,
	output logic        [15:0] rear_brake_position,
	output logic               next_mode
);

	ipts_pkg::cfg_t    cfg_q;
	ipts_pkg::item_t   item_s1;
	logic              valid_s1;
	logic [15:0]       accum_q;
	ipts_pkg::result_t result_d;
	ipts_pkg::result_t result_q;
	logic              out_valid_q;
	logic              advance;
	logic              in_take;

	// Configuration registers; unlisted indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain          <= ipts_pkg::KP_GAIN_RESET;
			cfg_q.kd_gain          <= ipts_pkg::KD_GAIN_RESET;
			cfg_q.throttle_floor   <= ipts_pkg::THROTTLE_FLOOR_RESET;
			cfg_q.throttle_ceiling <= ipts_pkg::THROTTLE_CEILING_RESET;
			cfg_q.brake_engaged    <= ipts_pkg::BRAKE_ENGAGED_RESET;
			cfg_q.brake_released   <= ipts_pkg::BRAKE_RELEASED_RESET;
			cfg_q.speed_limit      <= ipts_pkg::SPEED_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (ipts_pkg::reg_index_t'(cfg_index))
				ipts_pkg::REG_KP_GAIN:          cfg_q.kp_gain          <= cfg_data;
				ipts_pkg::REG_KD_GAIN:          cfg_q.kd_gain          <= cfg_data;
				ipts_pkg::REG_THROTTLE_FLOOR:   cfg_q.throttle_floor   <= cfg_data;
				ipts_pkg::REG_THROTTLE_CEILING: cfg_q.throttle_ceiling <= cfg_data;
				ipts_pkg::REG_BRAKE_ENGAGED:    cfg_q.brake_engaged    <= cfg_data;
				ipts_pkg::REG_BRAKE_RELEASED:   cfg_q.brake_released   <= cfg_data;
				ipts_pkg::REG_SPEED_LIMIT:      cfg_q.speed_limit      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.error_now        <= error_now;
			item_s1.error_prev       <= error_prev;
			item_s1.error_older      <= error_older;
			item_s1.velocity_command <= velocity_command;
			item_s1.steer_angle_in   <= steer_angle_in;
			item_s1.clutch_direction <= clutch_direction;
			item_s1.wheel_speed      <= wheel_speed;
		end
	end

	ipts_datapath u_datapath (
		.cfg    (cfg_q),
		.accum  (accum_q),
		.item   (item_s1),
		.result (result_d)
	);

	// Accumulator only commits when its word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= 16'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			accum_q     <= result_d.throttle_position;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign throttle_position   = result_q.throttle_position;
	assign steer_degrees       = result_q.steer_degrees;
	assign rear_brake_position = result_q.rear_brake_position;
	assign next_mode           = result_q.next_mode;

endmodule

// File: src/ipts_datapath.sv
// Combinational step logic: PD increment and clamp, steering conversion,
// rear brake select and braking request. Depends on ipts_pkg.
module ipts_datapath (
	input  ipts_pkg::cfg_t    cfg,
	input  logic [15:0]       accum,
	input  ipts_pkg::item_t   item,
	output ipts_pkg::result_t result
);

	logic signed [16:0] d1;
	logic signed [16:0] d2;
	logic signed [17:0] dd;
	logic signed [33:0] p_kp;
	logic signed [34:0] p_kd;
	logic signed [35:0] pd_sum;
	logic signed [27:0] incr;
	logic signed [28:0] acc_sum;
	logic signed [28:0] floor_ext;
	logic signed [28:0] ceil_ext;
	logic signed [28:0] after_floor;

	logic [12:0] mrad_mag;
	logic [31:0] steer_prod;
	logic [31:0] steer_rnd;
	logic [15:0] deg_mag;
	logic [15:0] wheel_mag;
	logic [15:0] cmd_mag;

	// Differences are exact at one extra bit each
	assign d1 = 17'(item.error_now) - 17'(item.error_prev);
	assign d2 = 17'(item.error_prev) - 17'(item.error_older);
	assign dd = 18'(d1) - 18'(d2);

	assign p_kp = $signed({1'b0, cfg.kp_gain}) * d1;
	assign p_kd = $signed({1'b0, cfg.kd_gain}) * dd;
	assign pd_sum = 36'(p_kp) + 36'(p_kd);
	// arithmetic shift is floor division by 256
	assign incr = 28'(pd_sum >>> 8);
	assign acc_sum = $signed({13'd0, accum}) + 29'(incr);

	assign floor_ext = $signed({13'd0, cfg.throttle_floor});
	assign ceil_ext  = $signed({13'd0, cfg.throttle_ceiling});

	assign after_floor = (acc_sum < floor_ext) ? floor_ext : acc_sum;
	// ceiling applied last so it wins over the floor
	assign result.throttle_position = (after_floor > ceil_ext) ? cfg.throttle_ceiling
	                                                           : after_floor[15:0];

	// Steering: magnitude, scale, round half away from zero, restore sign
	assign mrad_mag   = item.steer_angle_in[12] ? 13'(-item.steer_angle_in)
	                                            : item.steer_angle_in;
	assign steer_prod = 32'(mrad_mag) * 32'(ipts_pkg::STEER_FACTOR_Q16);
	assign steer_rnd  = steer_prod + ipts_pkg::STEER_ROUND;
	assign deg_mag    = steer_rnd[31:16];
	assign result.steer_degrees = item.steer_angle_in[12] ? $signed(16'(-deg_mag))
	                                                      : $signed(deg_mag);

	assign wheel_mag = item.wheel_speed[15] ? 16'(-item.wheel_speed) : item.wheel_speed;
	assign result.rear_brake_position = (wheel_mag >= {1'b0, cfg.speed_limit})
	                                    ? cfg.brake_engaged : cfg.brake_released;

	assign cmd_mag = item.velocity_command[15] ? 16'(-item.velocity_command)
	                                           : item.velocity_command;
	assign result.next_mode = (cmd_mag <= ipts_pkg::CMD_DEADBAND)
		|| ((item.clutch_direction == ipts_pkg::GEAR_FORWARD) && item.velocity_command[15])
		|| ((item.clutch_direction == ipts_pkg::GEAR_REVERSE) && !item.velocity_command[15]);

endmodule
